@@ src/xcbc_pkg.sv @@
// Shared types, register map and constants for the XTEA CBC block engine.
// Depends on nothing; used by xtea_cbc_block_engine and the testbench.
`timescale 1ns / 1ps

package xcbc_pkg;

    localparam int unsigned XCBC_ADDR_W = 5;

    localparam logic [31:0] XCBC_DELTA      = 32'h9E37_79B9;
    localparam logic [6:0]  XCBC_MAX_CYCLES = 7'd64;

    // Register reset values.
    localparam logic [31:0] RST_KEY0   = 32'hF0E1_D2C3;
    localparam logic [31:0] RST_KEY1   = 32'hB4A5_9687;
    localparam logic [31:0] RST_KEY2   = 32'h7869_5A4B;
    localparam logic [31:0] RST_KEY3   = 32'h3C2D_1E0F;
    localparam logic [31:0] RST_IV0    = 32'h1122_3344;
    localparam logic [31:0] RST_IV1    = 32'h5566_7788;
    localparam logic        RST_DIR    = 1'b1;
    localparam logic [6:0]  RST_ROUNDS = 7'd32;

    // Register indexes (byte address divided by four).
    localparam logic [2:0] REG_KEY0   = 3'd0;
    localparam logic [2:0] REG_KEY1   = 3'd1;
    localparam logic [2:0] REG_KEY2   = 3'd2;
    localparam logic [2:0] REG_KEY3   = 3'd3;
    localparam logic [2:0] REG_IV0    = 3'd4;
    localparam logic [2:0] REG_IV1    = 3'd5;
    localparam logic [2:0] REG_DIR    = 3'd6;
    localparam logic [2:0] REG_ROUNDS = 3'd7;

    localparam logic DIR_ENCRYPT = 1'b1;

    typedef struct packed {
        logic [31:0] block_first_word;
        logic [31:0] block_second_word;
        logic        first_block;
    } in_item_t;

    typedef struct packed {
        logic [31:0] out_first_word;
        logic [31:0] out_second_word;
    } out_item_t;

    typedef enum logic {
        ST_IDLE,
        ST_CALC
    } state_t;

    // XTEA mixing function of one word.
    function automatic logic [31:0] xtea_mix(input logic [31:0] v);
        return ((v << 4) ^ (v >> 5)) + v;
    endfunction

endpackage

@@ src/xtea_cbc_block_engine.sv @@
// XTEA block cipher in CBC mode with an APB register port and one shared half-round unit.
// Depends on xcbc_pkg for the request/result types, register map and constants.
`timescale 1ns / 1ps

// Usage:
// A request on the s_ channel carries one 64-bit block as two 32-bit words plus a
// first_block flag. When first_block is set, the chaining value is reloaded from the
// IV registers before the block is processed. The direction register selects encrypt
// (output is the cipher of block xor chain and becomes the next chain) or decrypt
// (output is the inverse cipher of the block, xored with the chain, and the block
// becomes the next chain). One result leaves on the m_ channel for every request.
// The cipher runs one half-round per clock through a single shared add/xor unit, then
// loads the result into the output register. A block runs N rounds (the round count,
// capped at 64) of two half-rounds each. s_ready is high only while no block is in the
// unit, so a new request is taken only once the previous block has left the unit. The
// finished result sits in an output register, so the next request is accepted while it
// waits; if the output register still holds an earlier result when a block finishes,
// the unit holds its finished block until the output register frees up.
// Reset (aresetn low at a clock edge) restores every APB register to its default value,
// clears the chaining value to zero and empties the unit and the output register.
// Registers are to be written through APB only while the block is idle; the block
// itself does not enforce this. pready is always high.
module xtea_cbc_block_engine (
    input  logic                                aclk,
    input  logic                                aresetn,
    // APB register port
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [xcbc_pkg::XCBC_ADDR_W-1:0]    paddr,
    input  logic [31:0]                         pwdata,
    output logic [31:0]                         prdata,
    output logic                                pready,
    // Request channel
    input  logic                                s_valid,
    output logic                                s_ready,
    input  xcbc_pkg::in_item_t                  s_data,
    // Result channel
    output logic                                m_valid,
    input  logic                                m_ready,
    output xcbc_pkg::out_item_t                 m_data
);

    // Configuration registers.
    logic [31:0] key_reg [4];
    logic [31:0] iv0_reg;
    logic [31:0] iv1_reg;
    logic        dir_reg;
    logic [6:0]  rounds_reg;

    // Sequencer and datapath registers.
    xcbc_pkg::state_t state_reg, state_next;
    logic [31:0] a_reg, a_next;
    logic [31:0] b_reg, b_next;
    logic [31:0] sum_reg, sum_next;
    logic [7:0]  steps_reg, steps_next;
    logic        phase_reg, phase_next;
    logic [63:0] chain_reg, chain_next;
    logic [63:0] hold_reg, hold_next;
    logic        m_valid_reg, m_valid_next;
    xcbc_pkg::out_item_t m_data_reg, m_data_next;

    logic        wr_en;
    logic [2:0]  reg_idx;
    logic        accept;
    logic        finish;
    logic        out_free;
    logic        busy_step;
    logic [6:0]  cycles_n;
    logic [38:0] dec_sum_prod;
    logic [63:0] chain_sel;

    // Shared half-round unit signals.
    logic        use_b;
    logic [31:0] unit_x;
    logic [31:0] unit_tgt;
    logic [1:0]  key_idx;
    logic [31:0] unit_f;
    logic [31:0] unit_res;

    assign pready  = 1'b1;
    assign reg_idx = paddr[xcbc_pkg::XCBC_ADDR_W-1:2];
    assign wr_en   = psel && penable && pwrite && pready;

    // Register writes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_reg[0] <= xcbc_pkg::RST_KEY0;
            key_reg[1] <= xcbc_pkg::RST_KEY1;
            key_reg[2] <= xcbc_pkg::RST_KEY2;
            key_reg[3] <= xcbc_pkg::RST_KEY3;
            iv0_reg    <= xcbc_pkg::RST_IV0;
            iv1_reg    <= xcbc_pkg::RST_IV1;
            dir_reg    <= xcbc_pkg::RST_DIR;
            rounds_reg <= xcbc_pkg::RST_ROUNDS;
        end else if (wr_en) begin
            unique case (reg_idx)
                xcbc_pkg::REG_KEY0:   key_reg[0] <= pwdata;
                xcbc_pkg::REG_KEY1:   key_reg[1] <= pwdata;
                xcbc_pkg::REG_KEY2:   key_reg[2] <= pwdata;
                xcbc_pkg::REG_KEY3:   key_reg[3] <= pwdata;
                xcbc_pkg::REG_IV0:    iv0_reg    <= pwdata;
                xcbc_pkg::REG_IV1:    iv1_reg    <= pwdata;
                xcbc_pkg::REG_DIR:    dir_reg    <= pwdata[0];
                xcbc_pkg::REG_ROUNDS: rounds_reg <= pwdata[6:0];
                default:              rounds_reg <= rounds_reg;
            endcase
        end
    end

    // Register reads.
    always_comb begin
        unique case (reg_idx)
            xcbc_pkg::REG_KEY0:   prdata = key_reg[0];
            xcbc_pkg::REG_KEY1:   prdata = key_reg[1];
            xcbc_pkg::REG_KEY2:   prdata = key_reg[2];
            xcbc_pkg::REG_KEY3:   prdata = key_reg[3];
            xcbc_pkg::REG_IV0:    prdata = iv0_reg;
            xcbc_pkg::REG_IV1:    prdata = iv1_reg;
            xcbc_pkg::REG_DIR:    prdata = {31'd0, dir_reg};
            xcbc_pkg::REG_ROUNDS: prdata = {25'd0, rounds_reg};
            default:              prdata = 32'd0;
        endcase
    end

    // Round counts above the maximum saturate; zero passes the block through the core.
    assign cycles_n     = (rounds_reg > xcbc_pkg::XCBC_MAX_CYCLES) ?
                          xcbc_pkg::XCBC_MAX_CYCLES : rounds_reg;
    assign dec_sum_prod = xcbc_pkg::XCBC_DELTA * cycles_n;
    assign chain_sel    = s_data.first_block ? {iv0_reg, iv1_reg} : chain_reg;

    // Shared half-round unit. Encryption updates the first word on even half-rounds,
    // decryption updates the second word first, so the unit picks its operands by
    // direction and phase.
    assign use_b    = (dir_reg == xcbc_pkg::DIR_ENCRYPT) ? !phase_reg : phase_reg;
    assign unit_x   = use_b ? b_reg : a_reg;
    assign unit_tgt = use_b ? a_reg : b_reg;
    assign key_idx  = use_b ? sum_reg[1:0] : sum_reg[12:11];
    assign unit_f   = xcbc_pkg::xtea_mix(unit_x) ^ (sum_reg + key_reg[key_idx]);
    assign unit_res = (dir_reg == xcbc_pkg::DIR_ENCRYPT) ?
                      (unit_tgt + unit_f) : (unit_tgt - unit_f);

    // Sequencer: next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            xcbc_pkg::ST_IDLE: begin
                if (s_valid) begin
                    state_next = xcbc_pkg::ST_CALC;
                end
            end
            xcbc_pkg::ST_CALC: begin
                if (steps_reg == 8'd0 && out_free) begin
                    state_next = xcbc_pkg::ST_IDLE;
                end
            end
            default: state_next = xcbc_pkg::ST_IDLE;
        endcase
    end

    // Sequencer: outputs.
    always_comb begin
        s_ready   = 1'b0;
        busy_step = 1'b0;
        finish    = 1'b0;
        unique case (state_reg)
            xcbc_pkg::ST_IDLE: s_ready = 1'b1;
            xcbc_pkg::ST_CALC: begin
                busy_step = (steps_reg != 8'd0);
                finish    = (steps_reg == 8'd0) && out_free;
            end
            default: s_ready = 1'b0;
        endcase
    end

    assign out_free = !m_valid_reg || m_ready;
    assign accept   = s_valid && s_ready;

    // Datapath next values.
    always_comb begin
        a_next       = a_reg;
        b_next       = b_reg;
        sum_next     = sum_reg;
        steps_next   = steps_reg;
        phase_next   = phase_reg;
        chain_next   = chain_reg;
        hold_next    = hold_reg;
        m_data_next  = m_data_reg;
        m_valid_next = m_valid_reg && !m_ready;

        if (accept) begin
            if (dir_reg == xcbc_pkg::DIR_ENCRYPT) begin
                a_next   = s_data.block_first_word ^ chain_sel[63:32];
                b_next   = s_data.block_second_word ^ chain_sel[31:0];
                sum_next = 32'd0;
            end else begin
                a_next   = s_data.block_first_word;
                b_next   = s_data.block_second_word;
                sum_next = dec_sum_prod[31:0];
            end
            steps_next = {cycles_n, 1'b0};
            phase_next = 1'b0;
            chain_next = chain_sel;
            hold_next  = {s_data.block_first_word, s_data.block_second_word};
        end else if (busy_step) begin
            if (use_b) begin
                a_next = unit_res;
            end else begin
                b_next = unit_res;
            end
            if (!phase_reg) begin
                sum_next = (dir_reg == xcbc_pkg::DIR_ENCRYPT) ?
                           (sum_reg + xcbc_pkg::XCBC_DELTA) :
                           (sum_reg - xcbc_pkg::XCBC_DELTA);
            end
            steps_next = steps_reg - 8'd1;
            phase_next = !phase_reg;
        end else if (finish) begin
            m_valid_next = 1'b1;
            if (dir_reg == xcbc_pkg::DIR_ENCRYPT) begin
                m_data_next.out_first_word  = a_reg;
                m_data_next.out_second_word = b_reg;
                chain_next                  = {a_reg, b_reg};
            end else begin
                m_data_next.out_first_word  = a_reg ^ chain_reg[63:32];
                m_data_next.out_second_word = b_reg ^ chain_reg[31:0];
                chain_next                  = hold_reg;
            end
        end
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= xcbc_pkg::ST_IDLE;
            steps_reg   <= 8'd0;
            phase_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
            chain_reg   <= 64'd0;
        end else begin
            state_reg   <= state_next;
            steps_reg   <= steps_next;
            phase_reg   <= phase_next;
            m_valid_reg <= m_valid_next;
            chain_reg   <= chain_next;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        a_reg      <= a_next;
        b_reg      <= b_next;
        sum_reg    <= sum_next;
        hold_reg   <= hold_next;
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // The step counter starts even on phase zero, so its low bit tracks the phase.
    a_step_phase : assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == xcbc_pkg::ST_CALC |-> steps_reg[0] == phase_reg)
        else $error("half-round phase out of step with counter");

    // A block always leaves the unit between full cycles.
    a_idle_phase : assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == xcbc_pkg::ST_IDLE |-> !phase_reg)
        else $error("unit went idle in the middle of a cycle");

    // The counter never exceeds two half-rounds per maximum cycle count.
    a_steps_max : assert property (@(posedge aclk) disable iff (!aresetn)
        steps_reg <= {xcbc_pkg::XCBC_MAX_CYCLES, 1'b0})
        else $error("step counter above maximum");

    // Finishing a block loads the output register and frees the unit.
    a_finish : assert property (@(posedge aclk) disable iff (!aresetn)
        finish |=> m_valid_reg && state_reg == xcbc_pkg::ST_IDLE)
        else $error("finished block not delivered to output register");

endmodule

@@ dv/testbench.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for the XTEA CBC block engine: random and directed blocks are
// checked against a CBC/XTEA predictor. Depends on xcbc_pkg and xtea_cbc_block_engine.

module testbench;

    localparam int RESET_CYCLES    = 12;
    localparam int RANDOM_PHASES   = 12;
    localparam int ITEMS_PER_PHASE = 50;
    localparam int MAX_REPORTS     = 10;
    // Longest block is 64 rounds of two half-rounds plus the output register load.
    localparam int DRAIN_CYCLES    = 2 * 64 + 16;

    // Every input of the engine holds a known value from time zero.
    logic                             aclk    = 1'b0;
    logic                             aresetn = 1'b0;
    logic                             psel    = 1'b0;
    logic                             penable = 1'b0;
    logic                             pwrite  = 1'b0;
    logic [xcbc_pkg::XCBC_ADDR_W-1:0] paddr   = '0;
    logic [31:0]                      pwdata  = '0;
    logic [31:0]                      prdata;
    logic                             pready;
    logic                             s_valid = 1'b0;
    logic                             s_ready;
    xcbc_pkg::in_item_t               s_data  = '0;
    logic                             m_valid;
    logic                             m_ready = 1'b0;
    xcbc_pkg::out_item_t              m_data;

    // Predictor copy of the register file and of the chaining value.
    logic [31:0] key_model [4];
    logic [31:0] iv_model [2];
    logic        dir_model;
    logic [6:0]  rounds_model;
    logic [31:0] chain_model [2];

    // Requests waiting for the driver, and the results that accepted requests owe.
    xcbc_pkg::in_item_t  pending_blocks [$];
    xcbc_pkg::out_item_t expected_blocks [$];

    // Traffic shaping. The stimulus process changes these flags only while the engine
    // is idle, so the driver and the receiver never see them change mid-block.
    bit sender_pauses   = 1'b1;
    bit receiver_stalls = 1'b1;
    int gap_left        = 0;
    int burst_left      = 1;
    int stall_left      = 0;
    int mismatch_count  = 0;

    xtea_cbc_block_engine DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    // 4 ns clock period.
    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // The XTEA round function: shifted copies of the word mixed and added back to it.
    function automatic logic [31:0] round_mix(input logic [31:0] w);
        logic [31:0] spread;
        spread = {w[27:0], 4'b0000} ^ {5'b00000, w[31:5]};
        return spread + w;
    endfunction

    // Computes the result of one request and advances the chaining value. Requests are
    // predicted in the order in which the engine accepts them, with the registers that
    // are in force at that moment.
    function automatic xcbc_pkg::out_item_t cbc_process(input xcbc_pkg::in_item_t req);
        logic [31:0]         a, b, sum, cycles;
        int unsigned         i;
        xcbc_pkg::out_item_t res;
        // Round counts above 64 saturate; zero leaves the block untouched by the core.
        cycles = (rounds_model > xcbc_pkg::XCBC_MAX_CYCLES) ?
                 {25'd0, xcbc_pkg::XCBC_MAX_CYCLES} : {25'd0, rounds_model};
        if (req.first_block) begin
            chain_model[0] = iv_model[0];
            chain_model[1] = iv_model[1];
        end
        if (dir_model == xcbc_pkg::DIR_ENCRYPT) begin
            // Encrypt: the chain is mixed into the plaintext and the cipher text
            // becomes the next chain.
            a   = req.block_first_word ^ chain_model[0];
            b   = req.block_second_word ^ chain_model[1];
            sum = '0;
            for (i = 0; i < cycles; i++) begin
                a   = a + (round_mix(b) ^ (sum + key_model[sum[1:0]]));
                sum = sum + xcbc_pkg::XCBC_DELTA;
                b   = b + (round_mix(a) ^ (sum + key_model[sum[12:11]]));
            end
            chain_model[0] = a;
            chain_model[1] = b;
        end else begin
            // Decrypt: rounds run backward from delta times the cycle count, the chain
            // is mixed in afterwards, and the incoming cipher text is the next chain.
            a   = req.block_first_word;
            b   = req.block_second_word;
            sum = xcbc_pkg::XCBC_DELTA * cycles;
            for (i = 0; i < cycles; i++) begin
                b   = b - (round_mix(a) ^ (sum + key_model[sum[12:11]]));
                sum = sum - xcbc_pkg::XCBC_DELTA;
                a   = a - (round_mix(b) ^ (sum + key_model[sum[1:0]]));
            end
            a = a ^ chain_model[0];
            b = b ^ chain_model[1];
            chain_model[0] = req.block_first_word;
            chain_model[1] = req.block_second_word;
        end
        res.out_first_word  = a;
        res.out_second_word = b;
        return res;
    endfunction

    // Length of the pause after a burst: often none, sometimes short, and now and
    // then longer than a whole block so that gaps land on every stage of the work.
    function automatic int pick_gap();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (!sender_pauses || roll < 50) begin
            return 0;
        end
        if (roll < 85) begin
            return $urandom_range(1, 8);
        end
        return $urandom_range(9, 140);
    endfunction

    // Random data word with the all-zero and all-one patterns mixed in.
    function automatic logic [31:0] rand_word();
        int unsigned roll;
        roll = $urandom_range(0, 9);
        if (roll == 0) begin
            return 32'h0000_0000;
        end
        if (roll == 1) begin
            return 32'hFFFF_FFFF;
        end
        return $urandom();
    endfunction

    // Request driver. A slot is free when nothing is offered or the current request is
    // taken at this edge; s_valid and s_data get at most one assignment per edge.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                expected_blocks.push_back(cbc_process(s_data));
            end
            if (!s_valid || s_ready) begin
                if (gap_left > 0) begin
                    gap_left = gap_left - 1;
                    s_valid <= 1'b0;
                end else if (pending_blocks.size() > 0) begin
                    s_valid <= 1'b1;
                    s_data  <= pending_blocks.pop_front();
                    burst_left = burst_left - 1;
                    if (burst_left <= 0) begin
                        burst_left = $urandom_range(1, 12);
                        gap_left   = pick_gap();
                    end
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Result receiver. It stalls on its own random pattern: mostly short stalls, sometimes
    // long ones that keep a finished block waiting in the engine.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left = stall_left - 1;
            m_ready <= 1'b0;
        end else if (receiver_stalls && $urandom_range(0, 99) < 15) begin
            stall_left = ($urandom_range(0, 9) < 7) ? $urandom_range(0, 2)
                                                    : $urandom_range(3, 149);
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // Result checker. Every result taken is compared with the oldest outstanding one.
    always @(posedge aclk) begin : result_check
        xcbc_pkg::out_item_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_blocks.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS) begin
                    $display("%0t ns: result %h %h arrived with no request outstanding",
                             $time, m_data.out_first_word, m_data.out_second_word);
                end
            end else begin
                want = expected_blocks.pop_front();
                if (m_data.out_first_word !== want.out_first_word ||
                    m_data.out_second_word !== want.out_second_word) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS) begin
                        $display("%0t ns: block result expected %h %h, got %h %h", $time,
                                 want.out_first_word, want.out_second_word,
                                 m_data.out_first_word, m_data.out_second_word);
                    end
                end
            end
        end
    end

    task automatic queue_block(input logic [31:0] w0, input logic [31:0] w1,
                               input logic first);
        xcbc_pkg::in_item_t req;
        req.block_first_word  = w0;
        req.block_second_word = w1;
        req.first_block       = first;
        pending_blocks.push_back(req);
    endtask

    // Waits until every queued request has been taken and every result has come back.
    // The check runs on the falling edge, after the driver and the checker have settled.
    // Each request owes one result, so the engine is idle once the last one arrives;
    // the short wait that follows only separates phases.
    task automatic wait_until_drained();
        do begin
            @(negedge aclk);
        end while (pending_blocks.size() != 0 || s_valid || expected_blocks.size() != 0);
        repeat (4) @(posedge aclk);
    endtask

    // APB write: a setup phase, then an access phase at whose closing edge the engine
    // stores the value. The predictor takes the value as the engine is meant to, with
    // the narrow registers keeping only their low bits.
    task automatic write_register(input logic [2:0] idx, input logic [31:0] value);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            xcbc_pkg::REG_KEY0, xcbc_pkg::REG_KEY1,
            xcbc_pkg::REG_KEY2, xcbc_pkg::REG_KEY3: begin
                key_model[idx[1:0]] = value;
            end
            xcbc_pkg::REG_IV0:    iv_model[0]  = value;
            xcbc_pkg::REG_IV1:    iv_model[1]  = value;
            xcbc_pkg::REG_DIR:    dir_model    = value[0];
            xcbc_pkg::REG_ROUNDS: rounds_model = value[6:0];
            default: ;
        endcase
    endtask

    initial begin : stimulus
        int          phase, queued, msg_len, k;
        int unsigned pick;
        logic [31:0] rounds_value;

        key_model[0]   = xcbc_pkg::RST_KEY0;
        key_model[1]   = xcbc_pkg::RST_KEY1;
        key_model[2]   = xcbc_pkg::RST_KEY2;
        key_model[3]   = xcbc_pkg::RST_KEY3;
        iv_model[0]    = xcbc_pkg::RST_IV0;
        iv_model[1]    = xcbc_pkg::RST_IV1;
        dir_model      = xcbc_pkg::RST_DIR;
        rounds_model   = xcbc_pkg::RST_ROUNDS;
        chain_model[0] = '0;
        chain_model[1] = '0;

        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Default registers, encrypt. The first requests come before any first-block
        // flag, so they chain against the zero value left by reset.
        queue_block(32'h0000_0000, 32'h0000_0000, 1'b0);
        queue_block(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
        queue_block(32'h0000_0000, 32'h0000_0000, 1'b1);
        queue_block(32'hAAAA_AAAA, 32'h5555_5555, 1'b0);
        wait_until_drained();

        // Decrypt with the default key, including a restart in the middle.
        write_register(xcbc_pkg::REG_DIR, 32'h0000_0000);
        queue_block(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
        queue_block(32'h0000_0000, 32'h0000_0000, 1'b0);
        queue_block(rand_word(), rand_word(), 1'b0);
        queue_block(32'h5555_5555, 32'hAAAA_AAAA, 1'b1);
        wait_until_drained();

        // Zero round count: the core is bypassed and only the chaining remains.
        write_register(xcbc_pkg::REG_KEY0, 32'h0000_0000);
        write_register(xcbc_pkg::REG_KEY1, 32'h0000_0000);
        write_register(xcbc_pkg::REG_KEY2, 32'h0000_0000);
        write_register(xcbc_pkg::REG_KEY3, 32'h0000_0000);
        write_register(xcbc_pkg::REG_IV0, 32'hFFFF_FFFF);
        write_register(xcbc_pkg::REG_IV1, 32'hFFFF_FFFF);
        write_register(xcbc_pkg::REG_DIR, 32'h0000_0001);
        write_register(xcbc_pkg::REG_ROUNDS, 32'h0000_0000);
        queue_block(32'h0000_0000, 32'h0000_0000, 1'b1);
        queue_block(32'hFFFF_FFFF, 32'h0000_0000, 1'b0);
        queue_block(32'h0000_0000, 32'hFFFF_FFFF, 1'b0);
        wait_until_drained();

        // All-one key, decrypt with the upper bits of the direction word set, and a
        // round count of 127 that saturates to 64.
        write_register(xcbc_pkg::REG_KEY0, 32'hFFFF_FFFF);
        write_register(xcbc_pkg::REG_KEY1, 32'hFFFF_FFFF);
        write_register(xcbc_pkg::REG_KEY2, 32'hFFFF_FFFF);
        write_register(xcbc_pkg::REG_KEY3, 32'hFFFF_FFFF);
        write_register(xcbc_pkg::REG_DIR, 32'hFFFF_FFFE);
        write_register(xcbc_pkg::REG_ROUNDS, 32'hFFFF_FFFF);
        queue_block(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
        queue_block(32'h0000_0000, 32'h0000_0000, 1'b0);
        queue_block(32'h8000_0000, 32'h0000_0001, 1'b0);
        wait_until_drained();

        // Single cycle, encrypt, random first and third key words.
        write_register(xcbc_pkg::REG_KEY0, rand_word());
        write_register(xcbc_pkg::REG_KEY2, rand_word());
        write_register(xcbc_pkg::REG_DIR, 32'h0000_0001);
        write_register(xcbc_pkg::REG_ROUNDS, 32'h0000_0001);
        queue_block(rand_word(), rand_word(), 1'b1);
        queue_block(rand_word(), rand_word(), 1'b0);
        wait_until_drained();

        // Largest legal round count, decrypt.
        write_register(xcbc_pkg::REG_DIR, 32'h0000_0000);
        write_register(xcbc_pkg::REG_ROUNDS, 32'h0000_0040);
        queue_block(rand_word(), rand_word(), 1'b1);
        queue_block(rand_word(), rand_word(), 1'b0);
        wait_until_drained();

        // Just above the cap, encrypt, zero IV.
        write_register(xcbc_pkg::REG_IV0, 32'h0000_0000);
        write_register(xcbc_pkg::REG_IV1, 32'h0000_0000);
        write_register(xcbc_pkg::REG_DIR, 32'h0000_0001);
        write_register(xcbc_pkg::REG_ROUNDS, 32'h0000_0041);
        queue_block(rand_word(), rand_word(), 1'b1);
        queue_block(rand_word(), rand_word(), 1'b0);
        wait_until_drained();

        // Random phases. Every fourth phase runs with no sender gaps and no receiver
        // stalls. Most traffic is messages that open with a first block and chain the
        // rest; some single requests carry a random flag.
        for (phase = 0; phase < RANDOM_PHASES; phase++) begin
            sender_pauses   = (phase % 4 != 0);
            receiver_stalls = (phase % 4 != 0);
            if ($urandom_range(0, 1)) write_register(xcbc_pkg::REG_KEY0, rand_word());
            if ($urandom_range(0, 1)) write_register(xcbc_pkg::REG_KEY1, rand_word());
            if ($urandom_range(0, 1)) write_register(xcbc_pkg::REG_KEY2, rand_word());
            if ($urandom_range(0, 1)) write_register(xcbc_pkg::REG_KEY3, rand_word());
            if ($urandom_range(0, 1)) write_register(xcbc_pkg::REG_IV0, rand_word());
            if ($urandom_range(0, 1)) write_register(xcbc_pkg::REG_IV1, rand_word());
            if ($urandom_range(0, 1)) write_register(xcbc_pkg::REG_DIR, $urandom());
            pick = $urandom_range(0, 9);
            if (pick == 0) begin
                rounds_value = 32'd0;
            end else if (pick == 1) begin
                rounds_value = 32'd64;
            end else if (pick == 2) begin
                rounds_value = $urandom_range(65, 127);
            end else begin
                rounds_value = $urandom_range(1, 63);
            end
            write_register(xcbc_pkg::REG_ROUNDS, rounds_value);

            queued = 0;
            while (queued < ITEMS_PER_PHASE) begin
                if ($urandom_range(0, 99) < 85) begin
                    msg_len = $urandom_range(1, 10);
                    for (k = 0; k < msg_len; k++) begin
                        queue_block(rand_word(), rand_word(), k == 0);
                    end
                    queued += msg_len;
                end else begin
                    queue_block(rand_word(), rand_word(), 1'($urandom_range(0, 1)));
                    queued++;
                end
            end
            wait_until_drained();
        end

        // Let any stray result show up before the verdict.
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatch_count == 0 && expected_blocks.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    // Watchdog. The slowest correct run, with every block at 64 rounds, the longest
    // sender gap and the longest receiver stall on each request, stays near 1.2 ms.
    initial begin : watchdog
        #6_000_000;
        $display("Mismatches found");
        $finish;
    end

endmodule
